FILE: rtl/tapa_pkg.sv
// ----------------------------------------------------------------------------
// tapa_pkg: shared constants and types for the triangle solver
// Result record, CORDIC arc tangent table (degrees, Q.24), output limits.
// ----------------------------------------------------------------------------
package tapa_pkg;

  localparam int CORDIC_STEPS    = 24;
  localparam int ANGLE_ROOT_BITS = 31;
  localparam int AREA_ROOT_BITS  = 40;
  localparam int NORM_BITS       = 62;

  localparam logic [23:0] ANGLE_FULL = 24'd11796480;
  localparam logic [39:0] AREA_MAX   = 40'hFF_FFFF_FFFF;
  localparam logic [25:0] PERIM_MAX  = 26'h3FF_FFFF;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic        valid_res;
    logic [25:0] perimeter;
    logic [23:0] angle_a;
    logic [23:0] angle_b;
    logic [23:0] angle_c;
    logic [39:0] area;
  } res_t;

endpackage

FILE: rtl/tapa_norm_cell.sv
// ----------------------------------------------------------------------------
// tapa_norm_cell: one step of the leading-zero normalizer
// Shifts a pair left by SH when the top SH bits of both are zero.
// ----------------------------------------------------------------------------
module tapa_norm_cell #(
  parameter int W  = 62,
  parameter int SH = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] u_in,
  input  logic [W-1:0] v_in,
  output logic [W-1:0] u_out,
  output logic [W-1:0] v_out
);
  import tapa_pkg::*;

  logic top_zero;

  assign top_zero = ~|(u_in[W-1 -: SH] | v_in[W-1 -: SH]);

  always_ff @(posedge clk) begin
    if (en) begin
      u_out <= top_zero ? (u_in << SH) : u_in;
      v_out <= top_zero ? (v_in << SH) : v_in;
    end
  end

endmodule

FILE: rtl/tapa_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tapa_sqrt_cell: one digit of a restoring integer square root
// Takes the next two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
module tapa_sqrt_cell #(
  parameter int N = 31
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N+1:0]   rem_in,
  input  logic [N-1:0]   root_in,
  input  logic [2*N-1:0] rad_in,
  output logic [N+1:0]   rem_out,
  output logic [N-1:0]   root_out,
  output logic [2*N-1:0] rad_out
);
  import tapa_pkg::*;

  logic [N+1:0] rs;
  logic [N+1:0] trial;
  logic [N+2:0] diff;

  // remainder stays below 2^N before the shift, so the top bits are zero
  assign rs    = {rem_in[N-1:0], rad_in[2*N-1 -: 2]};
  assign trial = {root_in, 2'b01};
  assign diff  = {1'b0, rs} - {1'b0, trial};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= rad_in << 2;
      if (!diff[N+2]) begin
        rem_out  <= diff[N+1:0];
        root_out <= {root_in[N-2:0], 1'b1};
      end else begin
        rem_out  <= rs;
        root_out <= {root_in[N-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/tapa_cordic_cell.sv
// ----------------------------------------------------------------------------
// tapa_cordic_cell: one vectoring CORDIC micro-rotation
// Drives y toward zero and accumulates the angle in degrees, Q.24.
// ----------------------------------------------------------------------------
module tapa_cordic_cell #(
  parameter int XW   = 36,
  parameter int ZW   = 34,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);
  import tapa_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_TAB[STEP]);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 y_pos;

  assign dx    = y_in >>> STEP;
  assign dy    = x_in >>> STEP;
  assign y_pos = !y_in[XW-1] && (y_in != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_pos) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN_STEP;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN_STEP;
      end
    end
  end

endmodule

FILE: rtl/triangle_angles_perimeter_area_top.sv
// ----------------------------------------------------------------------------
// triangle_angles_perimeter_area_top: pipelined triangle solver
// Validity, perimeter, half-angle CORDIC angles and Heron area.
// ----------------------------------------------------------------------------
// Latency is set by the angle path (normalizer, 31 square root cells,
//   24 CORDIC cells).
// Throughput: one request per cycle while the skid entry is empty; a two-entry output stage holds results.
// Reset: rst clears the stage valid flags, out_valid and skid_v; data registers are not reset.
module triangle_angles_perimeter_area_top #(
  parameter int SIDE_WIDTH = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SIDE_WIDTH-1:0] side_a,
  input  logic [SIDE_WIDTH-1:0] side_b,
  input  logic [SIDE_WIDTH-1:0] side_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  valid_res,
  output logic [25:0]           perimeter,
  output logic [23:0]           angle_a,
  output logic [23:0]           angle_b,
  output logic [23:0]           angle_c,
  output logic [39:0]           area
);
  import tapa_pkg::*;

  localparam int SW       = SIDE_WIDTH;
  localparam int PSW      = SW + 2;
  localparam int DW       = SW + 1;
  localparam int UW       = 2 * SW + 3;
  localparam int NW       = (UW > NORM_BITS) ? UW : NORM_BITS;
  localparam int NS       = $clog2(NW);
  localparam int RN       = ANGLE_ROOT_BITS;
  localparam int AN       = AREA_ROOT_BITS;
  localparam int XW       = RN + 5;
  localparam int ZW       = 34;
  localparam int HL       = (UW + 1) / 2;
  localparam int HU       = UW - HL;
  localparam int PW       = 2 * UW;
  localparam int SA       = 2 * FRAC_BITS + 4;
  localparam int CE       = 2 + NS + RN + CORDIC_STEPS;
  localparam int L        = CE + 2;
  localparam int AREA_END = 5 + AN;
  localparam int SIDE_DLY = L - 2;
  localparam int AREA_DLY = L - 1 - AREA_END;
  localparam int PXW      = (PSW > 26) ? PSW : 26;

  logic       en;
  logic       push;
  logic       skid_v;
  logic [L:1] vld;

  assign en       = !skid_v;
  assign in_ready = en;
  assign push     = vld[L] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-1:1], in_valid};
    end
  end

  // ---- stage 1: sums and triangle check
  logic [DW-1:0]  s_ab, s_ac, s_bc;
  logic [PSW-1:0] p1;
  logic [DW-1:0]  pa1, pb1, pc1;
  logic           ok1;

  assign s_ab = DW'(side_a) + DW'(side_b);
  assign s_ac = DW'(side_a) + DW'(side_c);
  assign s_bc = DW'(side_b) + DW'(side_c);

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= PSW'(side_a) + PSW'(side_b) + PSW'(side_c);
      pa1 <= s_bc - DW'(side_a);
      pb1 <= s_ac - DW'(side_b);
      pc1 <= s_ab - DW'(side_c);
      ok1 <= (s_ab > DW'(side_c)) && (s_ac > DW'(side_b)) && (s_bc > DW'(side_a));
    end
  end

  // ---- stage 2: half-angle products
  logic [UW-1:0]  u_ang [2];
  logic [UW-1:0]  v_ang [2];
  logic [PXW-1:0] p_ext;
  logic [25:0]    perim_sat;

  assign p_ext     = PXW'(p1);
  assign perim_sat = (p_ext > PXW'(PERIM_MAX)) ? PERIM_MAX : p_ext[25:0];

  always_ff @(posedge clk) begin
    if (en) begin
      u_ang[0] <= UW'(p1) * UW'(pa1);
      v_ang[0] <= UW'(pb1) * UW'(pc1);
      u_ang[1] <= UW'(p1) * UW'(pb1);
      v_ang[1] <= UW'(pa1) * UW'(pc1);
    end
  end

  // carry validity and perimeter down to the last stage
  logic [26:0] side_q [SIDE_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= {ok1, perim_sat};
      for (int k = 1; k < SIDE_DLY; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---- area: split product, sum, scale, square root
  logic [HL-1:0]      ul, vl;
  logic [HU-1:0]      uh, vh;
  logic [2*HL-1:0]    pp_ll;
  logic [HL+HU-1:0]   pp_lh, pp_hl;
  logic [2*HU-1:0]    pp_hh;
  logic [PW-1:0]      prod4;
  logic [PW+79:0]     prod_sh;
  logic [79:0]        rad5;
  logic               sat5;

  assign ul = u_ang[0][HL-1:0];
  assign uh = u_ang[0][UW-1:HL];
  assign vl = v_ang[0][HL-1:0];
  assign vh = v_ang[0][UW-1:HL];
  assign prod_sh = {80'b0, prod4} >> SA;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= (2*HL)'(ul) * (2*HL)'(vl);
      pp_lh <= (HL+HU)'(ul) * (HL+HU)'(vh);
      pp_hl <= (HL+HU)'(uh) * (HL+HU)'(vl);
      pp_hh <= (2*HU)'(uh) * (2*HU)'(vh);
      prod4 <= PW'(pp_ll) + ((PW'(pp_lh) + PW'(pp_hl)) << HL) + (PW'(pp_hh) << (2*HL));
      rad5  <= prod_sh[79:0];
      sat5  <= |prod_sh[PW+79:80];
    end
  end

  logic [AN+1:0]   arem  [AN+1];
  logic [AN-1:0]   aroot [AN+1];
  logic [2*AN-1:0] arad  [AN+1];
  logic            asat  [AN];
  logic [39:0]     area_end;
  logic [39:0]     area_q [AREA_DLY];

  assign arem[0]  = '0;
  assign aroot[0] = '0;
  assign arad[0]  = rad5;

  for (genvar k = 0; k < AN; k++) begin : g_area
    tapa_sqrt_cell #(.N(AN)) u_sqrt (
      .clk      (clk),
      .en       (en),
      .rem_in   (arem[k]),
      .root_in  (aroot[k]),
      .rad_in   (arad[k]),
      .rem_out  (arem[k+1]),
      .root_out (aroot[k+1]),
      .rad_out  (arad[k+1])
    );
  end

  assign area_end = asat[AN-1] ? AREA_MAX : aroot[AN];

  always_ff @(posedge clk) begin
    if (en) begin
      asat[0] <= sat5;
      for (int k = 1; k < AN; k++) begin
        asat[k] <= asat[k-1];
      end
      area_q[0] <= area_end;
      for (int k = 1; k < AREA_DLY; k++) begin
        area_q[k] <= area_q[k-1];
      end
    end
  end

  // ---- angles: normalize, two square roots, CORDIC, round and clamp
  logic [23:0] ang_q [2];

  for (genvar g = 0; g < 2; g++) begin : g_ang
    logic [NW-1:0]          nu    [NS+1];
    logic [NW-1:0]          nv    [NS+1];
    logic [RN+1:0]          xrem  [RN+1];
    logic [RN-1:0]          xroot [RN+1];
    logic [2*RN-1:0]        xrad  [RN+1];
    logic [RN+1:0]          yrem  [RN+1];
    logic [RN-1:0]          yroot [RN+1];
    logic [2*RN-1:0]        yrad  [RN+1];
    logic signed [XW-1:0]   cx    [CORDIC_STEPS+1];
    logic signed [XW-1:0]   cy    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   cz    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   zsum;
    logic [ZW-8:0]          zr;

    assign nu[0] = NW'(u_ang[g]);
    assign nv[0] = NW'(v_ang[g]);

    for (genvar j = 0; j < NS; j++) begin : g_norm
      tapa_norm_cell #(.W(NW), .SH(1 << (NS - 1 - j))) u_norm (
        .clk   (clk),
        .en    (en),
        .u_in  (nu[j]),
        .v_in  (nv[j]),
        .u_out (nu[j+1]),
        .v_out (nv[j+1])
      );
    end

    assign xrem[0]  = '0;
    assign xroot[0] = '0;
    assign xrad[0]  = nu[NS][NW-1 -: 2*RN];
    assign yrem[0]  = '0;
    assign yroot[0] = '0;
    assign yrad[0]  = nv[NS][NW-1 -: 2*RN];

    for (genvar k = 0; k < RN; k++) begin : g_root
      tapa_sqrt_cell #(.N(RN)) u_sqrt_x (
        .clk      (clk),
        .en       (en),
        .rem_in   (xrem[k]),
        .root_in  (xroot[k]),
        .rad_in   (xrad[k]),
        .rem_out  (xrem[k+1]),
        .root_out (xroot[k+1]),
        .rad_out  (xrad[k+1])
      );
      tapa_sqrt_cell #(.N(RN)) u_sqrt_y (
        .clk      (clk),
        .en       (en),
        .rem_in   (yrem[k]),
        .root_in  (yroot[k]),
        .rad_in   (yrad[k]),
        .rem_out  (yrem[k+1]),
        .root_out (yroot[k+1]),
        .rad_out  (yrad[k+1])
      );
    end

    assign cx[0] = $signed(XW'(xroot[RN]));
    assign cy[0] = $signed(XW'(yroot[RN]));
    assign cz[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      tapa_cordic_cell #(.XW(XW), .ZW(ZW), .STEP(i)) u_cordic (
        .clk   (clk),
        .en    (en),
        .x_in  (cx[i]),
        .y_in  (cy[i]),
        .z_in  (cz[i]),
        .x_out (cx[i+1]),
        .y_out (cy[i+1]),
        .z_out (cz[i+1])
      );
    end

    // double the half angle and round to Q.16
    assign zsum = cz[CORDIC_STEPS] + ZW'(64);
    assign zr   = zsum[ZW-1:7];

    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[CORDIC_STEPS][ZW-1]) begin
          ang_q[g] <= '0;
        end else if (zr > (ZW-7)'(ANGLE_FULL)) begin
          ang_q[g] <= ANGLE_FULL;
        end else begin
          ang_q[g] <= zr[23:0];
        end
      end
    end
  end

  // ---- last stage: third angle and invalid masking
  logic [24:0] ang_sum;
  logic        ok_end;
  res_t        fin;
  res_t        skid;
  res_t        out_q;

  assign ang_sum = {1'b0, ang_q[0]} + {1'b0, ang_q[1]};
  assign ok_end  = side_q[SIDE_DLY-1][26];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ok_end) begin
        fin.valid_res <= 1'b1;
        fin.perimeter <= side_q[SIDE_DLY-1][25:0];
        fin.angle_a   <= ang_q[0];
        fin.angle_b   <= ang_q[1];
        fin.angle_c   <= (ang_sum > {1'b0, ANGLE_FULL}) ? '0 :
                         ANGLE_FULL - ang_sum[23:0];
        fin.area      <= area_q[AREA_DLY-1];
      end else begin
        fin <= '0;
      end
    end
  end

  // ---- output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_q <= skid_v ? skid : fin;
    end else if (push) begin
      skid <= fin;
    end
  end

  assign valid_res = out_q.valid_res;
  assign perimeter = out_q.perimeter;
  assign angle_a   = out_q.angle_a;
  assign angle_b   = out_q.angle_b;
  assign angle_c   = out_q.angle_c;
  assign area      = out_q.area;

  // ---- checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid entry held without an output result");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled while output was free");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> perimeter == '0 && angle_a == '0 &&
      angle_b == '0 && angle_c == '0 && area == '0)
    else $error("invalid triangle with nonzero results");

  a_angle_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res && ({1'b0, angle_a} + {1'b0, angle_b} <= {1'b0, ANGLE_FULL})
      |-> {1'b0, angle_a} + {1'b0, angle_b} + {1'b0, angle_c} == {1'b0, ANGLE_FULL})
    else $error("angles do not add up to 180 degrees");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_a <= ANGLE_FULL && angle_b <= ANGLE_FULL)
    else $error("angle above 180 degrees");

endmodule

FILE: dv/triangle_angles_perimeter_area_top_tb.sv
// ----------------------------------------------------------------------------
// triangle_angles_perimeter_area_top_tb: self-checking bench for the solver
// Drives side triples through the request channel, predicts validity,
// perimeter, half-angle CORDIC angles and Heron area in wide integer math,
// and compares every result in order under varying idle and stall rates.
// ----------------------------------------------------------------------------
module triangle_angles_perimeter_area_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tapa_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] side_a = '0;
  logic [23:0] side_b = '0;
  logic [23:0] side_c = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        valid_res;
  logic [25:0] perimeter;
  logic [23:0] angle_a;
  logic [23:0] angle_b;
  logic [23:0] angle_c;
  logic [39:0] area;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatches = 0;
  int   cycles = 0;
  res_t solutions_due [$];

  typedef struct {
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] c;
    bit          known;
    res_t        sol;
  } triple_t;

  triangle_angles_perimeter_area_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .side_a(side_a), .side_b(side_b), .side_c(side_c),
    .out_valid(out_valid), .out_ready(out_ready), .valid_res(valid_res),
    .perimeter(perimeter), .angle_a(angle_a), .angle_b(angle_b),
    .angle_c(angle_c), .area(area)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int bit_length(logic [159:0] v);
    for (int k = 159; k >= 0; k--)
      if (v[k]) return k + 1;
    return 0;
  endfunction

  function automatic logic [63:0] int_root(logic [159:0] n, int nbits);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [159:0] tw;
    r = '0;
    for (int k = nbits - 1; k >= 0; k--) begin
      t = r | (64'd1 << k);
      tw = 160'(t);
      if (tw * tw <= n) r = t;
    end
    return r;
  endfunction

  // full angle with tan^2(angle/2) = v/u, Q8.16 degrees
  function automatic logic [23:0] half_angle_deg(logic [159:0] u, logic [159:0] v);
    logic [159:0] us;
    logic [159:0] vs;
    int           lu;
    int           lv;
    int           sh;
    longint       x;
    longint       y;
    longint       z;
    longint       dx;
    longint       dy;
    longint       res;
    lu = bit_length(u);
    lv = bit_length(v);
    sh = (lu > lv ? lu : lv) - NORM_BITS;
    if (sh >= 0) begin
      us = u >> sh;
      vs = v >> sh;
    end else begin
      us = u << (-sh);
      vs = v << (-sh);
    end
    x = longint'(int_root(us, ANGLE_ROOT_BITS));
    y = longint'(int_root(vs, ANGLE_ROOT_BITS));
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) return '0;
    res = (z + 64) >>> 7;
    if (res > longint'(ANGLE_FULL)) res = longint'(ANGLE_FULL);
    return res[23:0];
  endfunction

  function automatic res_t solve_triangle(logic [23:0] sa, logic [23:0] sb, logic [23:0] sc);
    res_t         s;
    logic [159:0] a;
    logic [159:0] b;
    logic [159:0] c;
    logic [159:0] p;
    logic [159:0] pa;
    logic [159:0] pb;
    logic [159:0] pc;
    logic [159:0] ua;
    logic [159:0] va;
    logic [159:0] prod;
    logic [63:0]  aa;
    logic [63:0]  ab;
    logic [63:0]  ar;
    s = '0;
    a = 160'(sa);
    b = 160'(sb);
    c = 160'(sc);
    if (!(a + b > c && a + c > b && b + c > a)) return s;
    p  = a + b + c;
    pa = b + c - a;
    pb = a + c - b;
    pc = a + b - c;
    ua = p * pa;
    va = pb * pc;
    aa = 64'(half_angle_deg(ua, va));
    ab = 64'(half_angle_deg(p * pb, pa * pc));
    s.valid_res = 1'b1;
    s.perimeter = (p > 160'(PERIM_MAX)) ? PERIM_MAX : p[25:0];
    s.angle_a = aa[23:0];
    s.angle_b = ab[23:0];
    s.angle_c = (aa + ab > 64'(ANGLE_FULL)) ? 24'd0 : 24'(64'(ANGLE_FULL) - aa - ab);
    prod = (ua * va) >> 20;
    ar = int_root(prod, AREA_ROOT_BITS);
    s.area = (bit_length(prod) > 80) ? AREA_MAX : ar[39:0];
    return s;
  endfunction

  task automatic send_triple(logic [23:0] a, logic [23:0] b, logic [23:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    side_a <= a;
    side_b <= b;
    side_c <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    solutions_due.push_back(solve_triangle(a, b, c));
  endtask

  task automatic send_random_triple();
    logic [23:0] mask;
    logic [24:0] lo;
    logic [24:0] hi;
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] c;
    mask = 24'hFF_FFFF >> $urandom_range(22, 0);
    a = 24'($urandom & 32'(mask));
    b = 24'($urandom & 32'(mask));
    if ($urandom_range(99) < 80) begin
      lo = ((a > b) ? 25'(a) - 25'(b) : 25'(b) - 25'(a)) + 25'd1;
      hi = 25'(a) + 25'(b) - 25'd1;
      if (hi > 25'hFF_FFFF) hi = 25'hFF_FFFF;
      c = (lo <= hi && 25'(a) + 25'(b) > 25'd0) ? 24'($urandom_range(32'(hi), 32'(lo))) :
          24'($urandom & 32'(mask));
    end else begin
      c = 24'($urandom & 32'(mask));
    end
    case ($urandom_range(2))
      0: send_triple(a, b, c);
      1: send_triple(c, a, b);
      default: send_triple(b, c, a);
    endcase
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{valid_res, perimeter, angle_a, angle_b, angle_c, area};
      if (solutions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = solutions_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  triple_t directed [17] = '{
    '{24'd0, 24'd0, 24'd0, 1'b1, '0},
    '{24'd0, 24'd1, 24'd1, 1'b1, '0},
    '{24'd1, 24'd1, 24'd2, 1'b1, '0},
    '{24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 1'b1, '0},
    '{24'hFF_FFFF, 24'h80_0000, 24'h7F_FFFF, 1'b1, '0},
    '{24'd100, 24'd200, 24'd301, 1'b1, '0},
    '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
    '{24'hFF_FFFF, 24'hFF_FFFF, 24'd1, 1'b0, '0},
    '{24'd1, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
    '{24'hFF_FFFF, 24'd1, 24'hFF_FFFF, 1'b0, '0},
    '{24'd1, 24'd1, 24'd1, 1'b0, '0},
    '{24'd256, 24'd256, 24'd256, 1'b0, '0},
    '{24'd768, 24'd1024, 24'd1280, 1'b0, '0},
    '{24'd100, 24'd200, 24'd299, 1'b0, '0},
    '{24'd5, 24'd5, 24'd9, 1'b0, '0},
    '{24'hFF_FFFF, 24'h80_0000, 24'h80_0000, 1'b0, '0},
    '{24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 1'b0, '0}
  };

  initial begin
    int phase_idle [4]  = '{0, 61, 0, 18};
    int phase_stall [4] = '{0, 0, 61, 18};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      if (directed[i].known && solve_triangle(directed[i].a, directed[i].b, directed[i].c)
          !== directed[i].sol) begin
        mismatches++;
        $display("table row %0d disagrees with prediction", i);
      end
      send_triple(directed[i].a, directed[i].b, directed[i].c);
    end
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      repeat (200) send_random_triple();
    end
    in_valid <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

FILE: files.f
rtl/tapa_pkg.sv
rtl/tapa_norm_cell.sv
rtl/tapa_sqrt_cell.sv
rtl/tapa_cordic_cell.sv
rtl/triangle_angles_perimeter_area_top.sv
dv/triangle_angles_perimeter_area_top_tb.sv
